// ===== sv/assert_macros.svh =====
// Assertion macros used by the deframer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Clocked assertion, checked during reset too.
`define ASSERT_CLK_ALWAYS(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ===== sv/lpfd_pkg.sv =====
// Shared types and constants of the length-prefixed frame deframer.
package lpfd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 4096;
    localparam int HEADER_BYTES        = 8;
    localparam int WORD_BYTES          = 4;
    localparam int HDR_POS_W           = 4;
    localparam int FLEN_W              = 13;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_LONG  = 2'd2
    } lpfd_status_t;

    typedef struct packed {
        logic [31:0]       protocol_id;
        logic [7:0]        payload_byte;
        logic              payload_present;
        logic              last_of_frame;
        lpfd_status_t      frame_status;
        logic [FLEN_W-1:0] frame_length;
    } lpfd_result_t;

endpackage

// ===== sv/lpfd_parser.sv =====
// Header assembly, length check and payload tagging for one word per cycle while in_fire is high.
module lpfd_parser #(
    parameter int MAX_FRAME_BYTES = lpfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic [7:0]           rx_byte,
    output logic                 res_valid,
    output lpfd_pkg::lpfd_result_t res
);
    import lpfd_pkg::*;

    localparam int LEFT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [31:0] MAX_LEN = 32'(MAX_FRAME_BYTES);
    localparam logic [HDR_POS_W-1:0] POS_PAYLOAD = HDR_POS_W'(HEADER_BYTES);
    localparam logic [HDR_POS_W-1:0] POS_LAST_HDR = HDR_POS_W'(HEADER_BYTES - 1);
    localparam logic [HDR_POS_W-1:0] POS_PROTO = HDR_POS_W'(WORD_BYTES);

    logic [HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic [31:0]          len_reg, len_next;
    logic [31:0]          proto_reg, proto_next;
    logic [LEFT_W-1:0]    left_reg, left_next;
    logic [LEFT_W-1:0]    left_dec;
    logic [31:0]          proto_full;

    always_comb
    begin
        hdr_pos_next = hdr_pos_reg;
        len_next     = len_reg;
        proto_next   = proto_reg;
        left_next    = left_reg;
        left_dec     = left_reg - LEFT_W'(1);
        proto_full   = {rx_byte, proto_reg[31:8]};
        res_valid    = 1'b0;
        res          = '{protocol_id: proto_reg, payload_byte: 8'd0, payload_present: 1'b0,
                         last_of_frame: 1'b1, frame_status: STATUS_OK,
                         frame_length: len_reg[FLEN_W-1:0]};
        if (in_fire)
        begin
            if (hdr_pos_reg == POS_PAYLOAD)
            begin
                left_next           = left_dec;
                res_valid           = 1'b1;
                res.payload_byte    = rx_byte;
                res.payload_present = 1'b1;
                res.last_of_frame   = (left_dec == '0);
                if (left_dec == '0)
                begin
                    hdr_pos_next = '0;
                end
            end
            else if (hdr_pos_reg < POS_PROTO)
            begin
                len_next     = {rx_byte, len_reg[31:8]};
                hdr_pos_next = hdr_pos_reg + HDR_POS_W'(1);
            end
            else
            begin
                proto_next   = proto_full;
                hdr_pos_next = hdr_pos_reg + HDR_POS_W'(1);
                if (hdr_pos_reg == POS_LAST_HDR)
                begin
                    res.protocol_id = proto_full;
                    if (len_reg < 32'(HEADER_BYTES))
                    begin
                        res_valid        = 1'b1;
                        res.frame_status = STATUS_SHORT;
                        hdr_pos_next     = '0;
                    end
                    else if (len_reg > MAX_LEN)
                    begin
                        res_valid        = 1'b1;
                        res.frame_status = STATUS_LONG;
                        res.frame_length = MAX_LEN[FLEN_W-1:0];
                        hdr_pos_next     = '0;
                    end
                    else if (len_reg == 32'(HEADER_BYTES))
                    begin
                        res_valid    = 1'b1;
                        hdr_pos_next = '0;
                    end
                    else
                    begin
                        left_next = LEFT_W'(len_reg - 32'(HEADER_BYTES));
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg <= '0;
            len_reg     <= '0;
            proto_reg   <= '0;
            left_reg    <= '0;
        end
        else
        begin
            hdr_pos_reg <= hdr_pos_next;
            len_reg     <= len_next;
            proto_reg   <= proto_next;
            left_reg    <= left_next;
        end
    end

endmodule

// ===== sv/lpfd_out_reg.sv =====
// Result register with valid/ready handshake toward the sink.
module lpfd_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   res_valid,
    input  lpfd_pkg::lpfd_result_t res,
    input  logic                   out_ready,
    output logic                   out_valid,
    output lpfd_pkg::lpfd_result_t out_res,
    output logic                   in_ready
);
    import lpfd_pkg::*;

    logic         valid_reg, valid_next;
    lpfd_result_t data_reg, data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = res;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== sv/length_prefixed_frame_deframer_core.sv =====
// Top level of the length-prefixed frame deframer.
// Takes one stream word per cycle while in_ready is high and gives its result, if any,
// in the next cycle from a result register fed by combinational header and payload
// logic. in_ready drops only while a result waits and out_ready is low. Header
// words give no result; each payload word, an empty frame and an illegal length give one.
`include "assert_macros.svh"

module length_prefixed_frame_deframer_core #(
    parameter int MAX_FRAME_BYTES = lpfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 protocol_id,
    output logic [7:0]                  payload_byte,
    output logic                        payload_present,
    output logic                        last_of_frame,
    output logic [1:0]                  frame_status,
    output logic [lpfd_pkg::FLEN_W-1:0] frame_length
);
    import lpfd_pkg::*;

    logic         in_fire;
    logic         res_valid;
    lpfd_result_t res;
    lpfd_result_t out_res;

    assign in_fire = in_valid && in_ready;

    lpfd_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .rx_byte  (rx_byte),
        .res_valid(res_valid),
        .res      (res)
    );

    lpfd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_fire),
        .res_valid(res_valid),
        .res      (res),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .out_res  (out_res),
        .in_ready (in_ready)
    );

    assign protocol_id     = out_res.protocol_id;
    assign payload_byte    = out_res.payload_byte;
    assign payload_present = out_res.payload_present;
    assign last_of_frame   = out_res.last_of_frame;
    assign frame_status    = 2'(out_res.frame_status);
    assign frame_length    = out_res.frame_length;

    `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "in_ready low with no result held")
    `ASSERT_CLK(a_error_closes_frame, clk, rst_n, (out_valid && frame_status != 2'(STATUS_OK)) |-> (last_of_frame && !payload_present), "error result not a closed empty result")
    `ASSERT_CLK(a_no_data_zero, clk, rst_n, (out_valid && !payload_present) |-> (payload_byte == 8'd0 && last_of_frame), "result without data is not zero and last")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the length-prefixed frame deframer core.
module testbench;
    import lpfd_pkg::*;

    localparam int MAX_LEN     = MAX_FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT = 800000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_ready;
    logic [31:0]       protocol_id;
    logic [7:0]        payload_byte;
    logic              payload_present;
    logic              last_of_frame;
    logic [1:0]        frame_status;
    logic [FLEN_W-1:0] frame_length;

    lpfd_result_t pending_results[$];
    int           hdr_count;
    int           bytes_left;
    logic [31:0]  len_acc;
    logic [31:0]  proto_acc;
    int           err_count;
    int           hold_cycles;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;

    length_prefixed_frame_deframer_core #(
        .MAX_FRAME_BYTES(MAX_LEN)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .protocol_id    (protocol_id),
        .payload_byte   (payload_byte),
        .payload_present(payload_present),
        .last_of_frame  (last_of_frame),
        .frame_status   (frame_status),
        .frame_length   (frame_length)
    );

    always #10 clk = ~clk;

    function automatic void deframe_word(input logic [7:0] b);
        lpfd_result_t r;
        r = '0;
        r.protocol_id = proto_acc;
        if (hdr_count >= HEADER_BYTES)
        begin
            if (bytes_left != 0)
                bytes_left--;
            r.payload_byte    = b;
            r.payload_present = 1'b1;
            r.last_of_frame   = (bytes_left == 0);
            r.frame_status    = STATUS_OK;
            r.frame_length    = (len_acc > MAX_LEN) ? FLEN_W'(MAX_LEN) : len_acc[FLEN_W-1:0];
            pending_results.push_back(r);
            if (bytes_left == 0)
                hdr_count = 0;
        end
        else if (hdr_count < WORD_BYTES)
        begin
            if (hdr_count == 0)
            begin
                len_acc   = '0;
                proto_acc = '0;
            end
            len_acc[8*hdr_count +: 8] = b;
            hdr_count++;
        end
        else
        begin
            proto_acc[8*(hdr_count-WORD_BYTES) +: 8] = b;
            hdr_count++;
            if (hdr_count == HEADER_BYTES)
            begin
                r.protocol_id   = proto_acc;
                r.last_of_frame = 1'b1;
                if (len_acc < HEADER_BYTES)
                begin
                    r.frame_status = STATUS_SHORT;
                    r.frame_length = len_acc[FLEN_W-1:0];
                end
                else if (len_acc > MAX_LEN)
                begin
                    r.frame_status = STATUS_LONG;
                    r.frame_length = FLEN_W'(MAX_LEN);
                end
                else
                begin
                    r.frame_status = STATUS_OK;
                    r.frame_length = len_acc[FLEN_W-1:0];
                end
                if (len_acc <= HEADER_BYTES || len_acc > MAX_LEN)
                begin
                    pending_results.push_back(r);
                    hdr_count = 0;
                end
                else
                    bytes_left = len_acc - HEADER_BYTES;
            end
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // input side first so a same-edge push never reorders the queue
    always @(posedge clk)
    begin
        lpfd_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                deframe_word(rx_byte);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual protocol %0h byte %0h",
                             $time, protocol_id, payload_byte);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("protocol_id", want.protocol_id, protocol_id);
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("payload_present", want.payload_present, payload_present);
                    check_field("last_of_frame", want.last_of_frame, last_of_frame);
                    check_field("frame_status", want.frame_status, frame_status);
                    check_field("frame_length", want.frame_length, frame_length);
                end
            end
        end
    end

    // receiver: random stalls plus an on-demand long hold-off
    initial
    begin
        int n;
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** length_prefixed_frame_deframer_core: FAILED **");
        $finish;
    end

    task automatic send_word(input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_header(input logic [31:0] len, input logic [31:0] proto);
        for (int i = 0; i < WORD_BYTES; i++)
            send_word(len[8*i +: 8]);
        for (int i = 0; i < WORD_BYTES; i++)
            send_word(proto[8*i +: 8]);
    endtask

    task automatic send_frame(input logic [31:0] proto, input int n_payload);
        send_header(n_payload + HEADER_BYTES, proto);
        repeat (n_payload) send_word(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_frames(input int n_words);
        int sent;
        int kind;
        int plen;
        sent = 0;
        while (sent < n_words)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                plen = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 600)
                                                    : $urandom_range(1, 24);
                send_frame($urandom, plen);
                sent += plen;
            end
            else if (kind < 78)
                send_frame($urandom, 0);
            else if (kind < 86)
                send_header($urandom_range(0, HEADER_BYTES - 1), $urandom);
            else if (kind < 94)
            begin
                if ($urandom_range(0, 1))
                    send_header($urandom_range(MAX_LEN + 1, 4 * MAX_LEN), $urandom);
                else
                    send_header($urandom | 32'h0001_0000, $urandom);
            end
            else
                send_header($urandom, $urandom);    // garbage header
            sent += HEADER_BYTES;
        end
    endtask

    task automatic test_empty_frame();
        send_frame(32'h0000_0000, 0);
        send_frame($urandom, 0);
    endtask

    task automatic test_short_length();
        send_header(32'd0, 32'hFFFF_FFFF);
        send_header(HEADER_BYTES - 1, $urandom);
    endtask

    task automatic test_long_length();
        send_header(MAX_LEN + 1, $urandom);
        send_header(32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_payload_extremes();
        send_header(HEADER_BYTES + 4, 32'hFFFF_FFFF);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'h5A);
        send_word(8'hA5);
        send_frame(32'h0000_0000, 1);
        wait_results();
    endtask

    // long lengths whose low bits alone would look short or legal
    task automatic test_length_masking();
        send_header(32'h0000_2008, $urandom);
        send_header(32'h1000_0003, $urandom);
    endtask

    task automatic test_backpressure();
        hold_cycles = 150;
        send_frame($urandom, 60);
        wait_results();
    endtask

    task automatic test_random_stream();
        random_frames(1300);
    endtask

    task automatic test_streaming_without_gaps();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_frames(200);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_byte  <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_frame();
        test_short_length();
        test_long_length();
        test_payload_extremes();
        test_length_masking();
        test_backpressure();
        test_random_stream();
        test_streaming_without_gaps();
        wait_results();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("** length_prefixed_frame_deframer_core: PASSED **");
        else
            $display("** length_prefixed_frame_deframer_core: FAILED **");
        $finish;
    end
endmodule
